// ----- src/dfas_pkg.sv -----
`timescale 1ns / 1ps
package dfas_pkg;
	localparam int ExpW = 11;
	localparam int FracW = 52;
	localparam int MantW = 53;
	localparam int SumW = 54;
	localparam logic [ExpW-1:0] ExpMax = 11'd2046;
	localparam logic [5:0] MaxShift = 6'd63;

	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_SUB = 1'b1
	} cmd_t;

	typedef struct packed {
		logic            sign;
		logic [ExpW-1:0] exp_l;
		logic [SumW-1:0] mag;
	} norm_in_t;

	function automatic logic [5:0] lzc54(input logic [SumW-1:0] v);
		logic [5:0] c;
		logic       hit;
		c = 6'd54;
		hit = 1'b0;
		for (int i = SumW - 1; i >= 0; i--) begin
			if (!hit && v[i]) begin
				c = 6'(SumW - 1 - i);
				hit = 1'b1;
			end
		end
		return c;
	endfunction
endpackage

// ----- src/double_float_add_sub_truncating_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle; the four-stage pipe (align, shift/add,
// leading-zero count, normalize) advances whenever the output is not stalled.
// Reset: arst_n asynchronous, clears all stage valid bits.
module double_float_add_sub_truncating_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic        command,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] sum_bits,
	output logic        range_error
);
	import dfas_pkg::*;

	logic     en;
	logic     valid_s2;
	norm_in_t data_s2;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	dfas_align u_align (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.operand_a(operand_a), .operand_b(operand_b), .command(command),
		.valid_s2(valid_s2), .data_s2(data_s2)
	);

	dfas_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_s2(valid_s2), .data_s2(data_s2),
		.valid_s4(out_valid), .sum_s4(sum_bits), .err_s4(range_error)
	);
endmodule

// ----- src/dfas_align.sv -----
`timescale 1ns / 1ps
module dfas_align (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [63:0]          operand_a,
	input  logic [63:0]          operand_b,
	input  logic                 command,
	output logic                 valid_s2,
	output dfas_pkg::norm_in_t   data_s2
);
	import dfas_pkg::*;

	logic            a_big;
	logic            sb;
	logic [ExpW-1:0] ea, eb;
	logic [MantW-1:0] ma, mb;
	logic [ExpW-1:0] gap_full;

	logic             valid_s1;
	logic             sl_s1, same_s1;
	logic [ExpW-1:0]  el_s1;
	logic [MantW-1:0] ml_s1, ms_s1;
	logic [5:0]       gap_s1;
	logic [MantW-1:0] ms_sh;

	always_comb begin
		sb = operand_b[63] ^ (cmd_t'(command) == CMD_SUB);
		ea = operand_a[62:52];
		eb = operand_b[62:52];
		ma = {ea != '0, operand_a[FracW-1:0]};
		mb = {eb != '0, operand_b[FracW-1:0]};
		a_big = (ea > eb) || ((ea == eb) && (ma > mb));
		gap_full = a_big ? ea - eb : eb - ea;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sl_s1   <= a_big ? operand_a[63] : sb;
			same_s1 <= operand_a[63] == sb;
			el_s1   <= a_big ? ea : eb;
			ml_s1   <= a_big ? ma : mb;
			ms_s1   <= a_big ? mb : ma;
			gap_s1  <= (gap_full > ExpW'(MaxShift)) ? MaxShift : gap_full[5:0];
		end
	end

	assign ms_sh = ms_s1 >> gap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.sign  <= sl_s1;
			data_s2.exp_l <= el_s1;
			data_s2.mag   <= same_s1 ? {1'b0, ml_s1} + {1'b0, ms_sh}
			                         : {1'b0, ml_s1} - {1'b0, ms_sh};
		end
	end
endmodule

// ----- src/dfas_norm.sv -----
`timescale 1ns / 1ps
module dfas_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_s2,
	input  dfas_pkg::norm_in_t data_s2,
	output logic               valid_s4,
	output logic [63:0]        sum_s4,
	output logic               err_s4
);
	import dfas_pkg::*;

	logic             valid_s3;
	norm_in_t         data_s3;
	logic [5:0]       lz_s3;
	logic signed [12:0] e;
	logic [SumW-1:0]  m_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= data_s2;
			lz_s3   <= lzc54(data_s2.mag);
		end
	end

	// msb = 53 - lz, shift = 1 - lz
	always_comb begin
		e = $signed({2'b00, data_s3.exp_l}) + 13'sd1 - $signed({7'd0, lz_s3});
		m_n = data_s3.mag << lz_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (data_s3.mag == '0) begin
				sum_s4 <= '0;
				err_s4 <= 1'b0;
			end else if (e < 0 || e > $signed({2'b00, ExpMax})) begin
				sum_s4 <= '0;
				err_s4 <= 1'b1;
			end else begin
				sum_s4 <= {data_s3.sign, e[ExpW-1:0], m_n[SumW-2:SumW-1-FracW]};
				err_s4 <= 1'b0;
			end
		end
	end
endmodule

// ----- src/dfas_checker.sv -----
`timescale 1ns / 1ps
module dfas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] sum_bits,
	input logic        range_error
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> sum_bits == 64'd0)
		else $error("range error with nonzero result");
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_bits))
		else $error("stalled item changed");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall |=> out_valid)
		else $error("item lost");
endmodule

bind double_float_add_sub_truncating_unit dfas_checker u_dfas_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits),
	.range_error(range_error)
);

// ----- dv/double_float_add_sub_truncating_unit_test.sv -----
`timescale 1ns / 1ps
module double_float_add_sub_truncating_unit_test;
	import dfas_pkg::*;

	typedef struct {
		logic [63:0] bits;
		logic        err;
	} sum_t;

	class sum_board;
		sum_t pending[$];
		int   errors;

		function sum_t add_doubles(logic [63:0] a, logic [63:0] b, cmd_t cmd);
			sum_t r;
			logic [63:0] ma, mb, ml, ms, m;
			logic [10:0] ea, eb, el, es;
			logic sa, sb, sl, a_big;
			int gap, msb, e;
			if (cmd == CMD_SUB)
				b[63] = ~b[63];
			sa = a[63];
			sb = b[63];
			ea = a[62:52];
			eb = b[62:52];
			ma = {12'd0, a[51:0]};
			mb = {12'd0, b[51:0]};
			if (ea != 0)
				ma[52] = 1'b1;
			if (eb != 0)
				mb[52] = 1'b1;
			a_big = (ea > eb) || (ea == eb && ma > mb);
			el = a_big ? ea : eb;
			es = a_big ? eb : ea;
			ml = a_big ? ma : mb;
			ms = a_big ? mb : ma;
			sl = a_big ? sa : sb;
			gap = int'(el) - int'(es);
			if (gap > 63)
				gap = 63;
			ms = ms >> gap;
			m = (sa == sb) ? ml + ms : ml - ms;
			r.bits = '0;
			r.err = 1'b0;
			if (m == 0)
				return r;
			msb = 0;
			for (int i = 0; i < 64; i++)
				if (m[i])
					msb = i;
			e = int'(el) + msb - 52;
			if (e > 2046 || e < 0) begin
				r.err = 1'b1;
				return r;
			end
			if (msb > 52)
				m = m >> (msb - 52);
			else
				m = m << (52 - msb);
			r.bits = {sl, e[10:0], m[51:0]};
			return r;
		endfunction

		function void note_item(logic [63:0] a, logic [63:0] b, cmd_t cmd);
			pending.push_back(add_doubles(a, b, cmd));
		endfunction

		function void check_sum(logic [63:0] bits, logic err);
			sum_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result sum_bits=%h range_error=%b", $time, bits, err);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (bits !== x.bits) begin
				$display("%0t: sum_bits expected %h actual %h", $time, x.bits, bits);
				errors++;
			end
			if (err !== x.err) begin
				$display("%0t: range_error expected %b actual %b", $time, x.err, err);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic command = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] sum_bits;
	logic range_error;

	sum_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold = 0;
	int cycles = 0;

	double_float_add_sub_truncating_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("double_float_add_sub_truncating_unit_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_sum(sum_bits, range_error);
		if (hold)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [63:0] rand_double();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v[62:52] = 11'd0;
			1: v[62:52] = 11'd2047;
			2: v[62:52] = 11'd2046;
			3: v[62:52] = 11'($urandom_range(1, 3));
			default: v[62:52] = 11'($urandom_range(900, 1150));
		endcase
		if ($urandom_range(5) == 0)
			v[51:0] = $urandom_range(1) ? '0 : '1;
		return v;
	endfunction

	task automatic send_item(logic [63:0] a, logic [63:0] b, cmd_t cmd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		command <= cmd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_item(a, b, cmd);
	endtask

	task automatic send_random(int n);
		logic [63:0] a, b;
		for (int i = 0; i < n; i++) begin
			a = rand_double();
			b = rand_double();
			case ($urandom_range(3))
				0: b = a;
				1: b = {~a[63], a[62:0]};
				2: b[62:52] = a[62:52] + 11'($urandom_range(2)) - 11'd1;
				default: ;
			endcase
			send_item(a, b, $urandom_range(1) ? CMD_SUB : CMD_ADD);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(64'h0, 64'h0, CMD_ADD);
		send_item(64'h3ff0000000000000, 64'h3ff0000000000000, CMD_SUB);
		send_item(64'h3ff0000000000000, 64'h4000000000000000, CMD_ADD);
		send_item(64'h7fefffffffffffff, 64'h7fefffffffffffff, CMD_ADD);
		send_item(64'h7ff0000000000000, 64'h0, CMD_ADD);
		send_item(64'hffffffffffffffff, 64'hffffffffffffffff, CMD_ADD);
		send_item(64'h0010000000000000, 64'h0010000000000001, CMD_SUB);
		send_item(64'h000fffffffffffff, 64'h0000000000000001, CMD_ADD);
		send_item(64'h0000000000000001, 64'h8000000000000000, CMD_SUB);
		send_item(64'h4340000000000000, 64'h3ff0000000000000, CMD_SUB);
		send_item(64'h7fe0000000000000, 64'h0010000000000000, CMD_ADD);
		send_item(64'h3ff0000000000000, 64'hbff0000000000000, CMD_ADD);
		send_item(64'h800fffffffffffff, 64'h8010000000000000, CMD_ADD);
		send_item(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, CMD_SUB);
		send_random(250);
		send_idle_pct = 73;
		send_random(250);
		send_idle_pct = 0;
		recv_stall_pct = 73;
		send_random(250);
		send_idle_pct = 19;
		recv_stall_pct = 19;
		send_random(250);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold <= 1'b1;
				repeat (60) @(posedge clk);
				hold <= 1'b0;
			end
		join_none
		send_random(300);
		send_random(350);
		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("double_float_add_sub_truncating_unit_test OK");
		else
			$display("double_float_add_sub_truncating_unit_test NOT OK");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/dfas_pkg.sv
src/dfas_align.sv
src/dfas_norm.sv
src/double_float_add_sub_truncating_unit.sv
src/dfas_checker.sv
dv/double_float_add_sub_truncating_unit_test.sv
